@@ rtl/psou_pkg.sv @@
// Shared types, field widths and register codes of the particle update unit.
package psou_pkg;

	localparam int PARTICLE_W      = 6;
	localparam int DIMENSION_W     = 5;
	localparam int PARTICLE_SLOTS  = 2 ** PARTICLE_W;
	localparam int DIMENSION_SLOTS = 2 ** DIMENSION_W;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 18;

	localparam logic [16:0] Q_ONE = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INERTIA_MIN    = 3'd0,
		REG_INERTIA_MAX    = 3'd1,
		REG_COGNITIVE_GAIN = 3'd2,
		REG_SOCIAL_GAIN    = 3'd3,
		REG_CONSTRICTION   = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		KIND_INIT = 1'b0,
		KIND_MOVE = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic [PARTICLE_W-1:0]    particle;
		logic [DIMENSION_W-1:0]   dimension;
		logic signed [31:0]       personal_best;
		logic signed [31:0]       global_best;
		logic signed [31:0]       start_velocity;
		logic [30:0]              speed_limit;
		logic [16:0]              progress;
	} item_t;

	typedef struct packed {
		logic [PARTICLE_W-1:0]    out_particle;
		logic [DIMENSION_W-1:0]   out_dimension;
		logic signed [31:0]       new_position;
		logic signed [31:0]       new_velocity;
		logic                     was_clamped;
	} result_t;

	typedef struct packed {
		logic [16:0] inertia_min;
		logic [16:0] inertia_max;
		logic [17:0] cognitive_gain;
		logic [17:0] social_gain;
		logic [16:0] constriction;
	} cfg_t;

	typedef struct packed {
		kind_t                  kind;
		logic [PARTICLE_W-1:0]  particle;
		logic [DIMENSION_W-1:0] dimension;
	} tag_t;

	localparam cfg_t CFG_RESET = '{
		inertia_min:    17'd26214,
		inertia_max:    17'd58982,
		cognitive_gain: 18'd183501,
		social_gain:    18'd85197,
		constriction:   17'd47831
	};

endpackage

@@ rtl/psou_item_if.sv @@
// Request channel: valid/ready handshake carrying one entry update request.
interface psou_item_if ();
	import psou_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/psou_result_if.sv @@
// Result channel: valid/ready handshake carrying one updated entry.
interface psou_result_if ();
	import psou_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/psou_cfg_regs.sv @@
// Configuration register file: inertia bounds, gains and constriction factor.
module psou_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [psou_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [psou_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output psou_pkg::cfg_t                      cfg
);
	import psou_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_INERTIA_MIN:    cfg_q.inertia_min    <= cfg_wdata[16:0];
				REG_INERTIA_MAX:    cfg_q.inertia_max    <= cfg_wdata[16:0];
				REG_COGNITIVE_GAIN: cfg_q.cognitive_gain <= cfg_wdata[17:0];
				REG_SOCIAL_GAIN:    cfg_q.social_gain    <= cfg_wdata[17:0];
				REG_CONSTRICTION:   cfg_q.constriction   <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/psou_addr_map.sv @@
// Maps particle and dimension to a flat entry index, wrapping out-of-range addresses.
module psou_addr_map #(
	parameter int PARTICLES  = 64,
	parameter int DIMENSIONS = 32,
	parameter int AW         = 11
) (
	input  logic [psou_pkg::PARTICLE_W-1:0]  particle,
	input  logic [psou_pkg::DIMENSION_W-1:0] dimension,
	output logic [AW-1:0]                    idx
);
	import psou_pkg::*;

	logic [AW-1:0] base_tab [PARTICLE_SLOTS];
	logic [AW-1:0] dmod_tab [DIMENSION_SLOTS];

	for (genvar gp = 0; gp < PARTICLE_SLOTS; gp++) begin : g_base
		assign base_tab[gp] = AW'((gp % PARTICLES) * DIMENSIONS);
	end

	for (genvar gd = 0; gd < DIMENSION_SLOTS; gd++) begin : g_dmod
		assign dmod_tab[gd] = AW'(gd % DIMENSIONS);
	end

	assign idx = base_tab[particle] + dmod_tab[dimension];

endmodule

@@ rtl/psou_entry_store.sv @@
// Position and velocity memories, one read and one write port, registered read.
module psou_entry_store #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_pos,
	output logic [31:0]   rd_vel,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_pos,
	input  logic [31:0]   wr_vel
);
	logic [31:0] pos_mem [DEPTH];
	logic [31:0] vel_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_mem[wr_addr] <= wr_pos;
			vel_mem[wr_addr] <= wr_vel;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_pos <= pos_mem[rd_addr];
			rd_vel <= vel_mem[rd_addr];
		end
	end

endmodule

@@ rtl/pso_particle_dimension_update_unit.sv @@
// Particle swarm update unit: top level with the eight-stage update pipeline.
//
// Each request updates one (particle, dimension) entry and returns exactly one result.
// Independent entries stream at one request per clock unless the result channel stalls;
// a request passes through seven pipeline stages and the output register. Every request
// reads the entry from the store on acceptance and writes it back when it leaves the last
// stage, so a request to an entry that is still in flight is held off until the earlier
// one has been written back. The position and velocity stores hold PARTICLES*DIMENSIONS
// words each and are undefined after reset; issue an init request for an entry before
// moving it. Out-of-range particle and dimension indexes wrap modulo PARTICLES and
// DIMENSIONS. Write configuration only while no request is in flight.
module pso_particle_dimension_update_unit #(
	parameter int PARTICLES  = 64,
	parameter int DIMENSIONS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [psou_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [psou_pkg::CFG_DATA_W-1:0] cfg_wdata,
	psou_item_if.sink                       item,
	psou_result_if.source                   result
);
	import psou_pkg::*;

	localparam int ENTRIES = PARTICLES * DIMENSIONS;
	localparam int AW      = $clog2(ENTRIES);

	cfg_t               cfg;
	logic [AW-1:0]      in_idx;
	logic               hazard;
	logic               accept;
	logic               ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld_out;
	logic               mem_we;
	logic [31:0]        rd_pos, rd_vel;

	logic [16:0]        ratio_sat;
	logic signed [17:0] span;
	logic signed [35:0] wprod;
	logic signed [19:0] w_round;
	logic signed [19:0] w_full;
	logic signed [31:0] pos_sel, vel_sel;
	logic signed [52:0] sum_c;
	logic signed [39:0] vr_ext, vlim;
	logic signed [31:0] vpos, vneg;
	logic               over, under;
	logic signed [31:0] vnew_c;
	logic               clamped_c;
	logic signed [32:0] psum;
	logic signed [31:0] pnew_c;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic out_valid_q;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7;
	logic [30:0] vmax_s1, vmax_s2, vmax_s3, vmax_s4, vmax_s5, vmax_s6, vmax_s7;
	logic signed [31:0] pbest_s1, gbest_s1, vstart_s1;
	logic signed [35:0] wprod_s1;
	logic [16:0]        w_s2;
	logic signed [32:0] dp_s2, dg_s2;
	logic signed [31:0] pos_s2, pos_s3, pos_s4, pos_s5, pos_s6, pos_s7;
	logic signed [31:0] vel_s2, vel_s3, vel_s4, vel_s5, vel_s6;
	logic signed [49:0] mv_s3;
	logic signed [51:0] mp_s3, mg_s3;
	logic signed [36:0] rs_s4;
	logic signed [54:0] prod_s5;
	logic signed [38:0] vr_s6;
	logic signed [31:0] vnew_s7;
	logic               clamped_s7;
	result_t            res_q;
	kind_t              out_kind_q;

	psou_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	psou_addr_map #(
		.PARTICLES  (PARTICLES),
		.DIMENSIONS (DIMENSIONS),
		.AW         (AW)
	) u_addr (
		.particle  (item.data.particle),
		.dimension (item.data.dimension),
		.idx       (in_idx)
	);

	psou_entry_store #(
		.DEPTH (ENTRIES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_idx),
		.rd_pos  (rd_pos),
		.rd_vel  (rd_vel),
		.wr_en   (mem_we),
		.wr_addr (idx_s7),
		.wr_pos  (pnew_c),
		.wr_vel  (vnew_s7)
	);

	// flow control: a stage loads when it is empty or its content moves on
	assign ld_out = !out_valid_q || result.ready;
	assign ld7    = !valid_s7 || ld_out;
	assign ld6    = !valid_s6 || ld7;
	assign ld5    = !valid_s5 || ld6;
	assign ld4    = !valid_s4 || ld5;
	assign ld3    = !valid_s3 || ld4;
	assign ld2    = !valid_s2 || ld3;
	assign ld1    = !valid_s1 || ld2;

	// an entry in flight has not been written back yet
	assign hazard = (valid_s1 && idx_s1 == in_idx) || (valid_s2 && idx_s2 == in_idx) ||
	                (valid_s3 && idx_s3 == in_idx) || (valid_s4 && idx_s4 == in_idx) ||
	                (valid_s5 && idx_s5 == in_idx) || (valid_s6 && idx_s6 == in_idx) ||
	                (valid_s7 && idx_s7 == in_idx);

	assign item.ready = ld1 && !hazard;
	assign accept     = item.valid && item.ready;
	assign mem_we     = valid_s7 && ld_out;

	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	// inertia product, in front of stage 1
	assign ratio_sat = (item.data.progress > Q_ONE) ? Q_ONE : item.data.progress;
	assign span      = $signed({1'b0, cfg.inertia_min}) - $signed({1'b0, cfg.inertia_max});
	assign wprod     = $signed({1'b0, ratio_sat}) * span;

	// stage 1 -> 2
	assign w_round = 20'((wprod_s1 + 36'sd32768) >>> 16);
	assign w_full  = $signed({3'b000, cfg.inertia_max}) + w_round;
	assign pos_sel = (tag_s1.kind == KIND_MOVE) ? $signed(rd_pos) : pbest_s1;
	assign vel_sel = (tag_s1.kind == KIND_MOVE) ? $signed(rd_vel) : vstart_s1;

	// stage 3 -> 4
	assign sum_c = 53'(mv_s3) + 53'(mp_s3) + 53'(mg_s3);

	// stage 6 -> 7: clamp
	assign vr_ext = 40'(vr_s6);
	assign vlim   = $signed({9'b0, vmax_s6});
	assign vpos   = $signed({1'b0, vmax_s6});
	assign vneg   = -$signed({1'b0, vmax_s6});
	assign over   = vr_ext > vlim;
	assign under  = vr_ext < -vlim;

	always_comb begin
		vnew_c    = vr_s6[31:0];
		clamped_c = 1'b0;
		if (tag_s6.kind == KIND_INIT) begin
			vnew_c = vel_s6;
		end else if (over) begin
			vnew_c    = vpos;
			clamped_c = 1'b1;
		end else if (under) begin
			vnew_c    = vneg;
			clamped_c = 1'b1;
		end
	end

	// stage 7 -> output: position update with saturation
	assign psum = 33'(pos_s7) + 33'(vnew_s7);

	always_comb begin
		pnew_c = psum[31:0];
		if (tag_s7.kind == KIND_INIT) begin
			pnew_c = pos_s7;
		end else if (psum[32] != psum[31]) begin
			pnew_c = psum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld1) valid_s1 <= accept;
			if (ld2) valid_s2 <= valid_s1;
			if (ld3) valid_s3 <= valid_s2;
			if (ld4) valid_s4 <= valid_s3;
			if (ld5) valid_s5 <= valid_s4;
			if (ld6) valid_s6 <= valid_s5;
			if (ld7) valid_s7 <= valid_s6;
			if (ld_out) out_valid_q <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			tag_s1.kind      <= item.data.kind;
			tag_s1.particle  <= item.data.particle;
			tag_s1.dimension <= item.data.dimension;
			idx_s1           <= in_idx;
			vmax_s1          <= item.data.speed_limit;
			pbest_s1         <= item.data.personal_best;
			gbest_s1         <= item.data.global_best;
			vstart_s1        <= item.data.start_velocity;
			wprod_s1         <= wprod;
		end
		if (ld2) begin
			tag_s2  <= tag_s1;
			idx_s2  <= idx_s1;
			vmax_s2 <= vmax_s1;
			w_s2    <= w_full[16:0];
			dp_s2   <= 33'(pbest_s1) - 33'(pos_sel);
			dg_s2   <= 33'(gbest_s1) - 33'(pos_sel);
			pos_s2  <= pos_sel;
			vel_s2  <= vel_sel;
		end
		if (ld3) begin
			tag_s3  <= tag_s2;
			idx_s3  <= idx_s2;
			vmax_s3 <= vmax_s2;
			pos_s3  <= pos_s2;
			vel_s3  <= vel_s2;
			mv_s3   <= vel_s2 * $signed({1'b0, w_s2});
			mp_s3   <= $signed({1'b0, cfg.cognitive_gain}) * dp_s2;
			mg_s3   <= $signed({1'b0, cfg.social_gain}) * dg_s2;
		end
		if (ld4) begin
			tag_s4  <= tag_s3;
			idx_s4  <= idx_s3;
			vmax_s4 <= vmax_s3;
			pos_s4  <= pos_s3;
			vel_s4  <= vel_s3;
			rs_s4   <= 37'((sum_c + 53'sd32768) >>> 16);
		end
		if (ld5) begin
			tag_s5  <= tag_s4;
			idx_s5  <= idx_s4;
			vmax_s5 <= vmax_s4;
			pos_s5  <= pos_s4;
			vel_s5  <= vel_s4;
			prod_s5 <= rs_s4 * $signed({1'b0, cfg.constriction});
		end
		if (ld6) begin
			tag_s6  <= tag_s5;
			idx_s6  <= idx_s5;
			vmax_s6 <= vmax_s5;
			pos_s6  <= pos_s5;
			vel_s6  <= vel_s5;
			vr_s6   <= 39'((prod_s5 + 55'sd32768) >>> 16);
		end
		if (ld7) begin
			tag_s7     <= tag_s6;
			idx_s7     <= idx_s6;
			vmax_s7    <= vmax_s6;
			pos_s7     <= pos_s6;
			vnew_s7    <= vnew_c;
			clamped_s7 <= clamped_c;
		end
		if (ld_out) begin
			res_q.out_particle  <= tag_s7.particle;
			res_q.out_dimension <= tag_s7.dimension;
			res_q.new_position  <= pnew_c;
			res_q.new_velocity  <= vnew_s7;
			res_q.was_clamped   <= clamped_s7;
			out_kind_q          <= tag_s7.kind;
		end
	end

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !(mem_we && idx_s7 == in_idx))
		else $error("entry read while its write-back is pending");

	a_vel_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s7 && tag_s7.kind == KIND_MOVE) |->
			(vnew_s7 <= $signed({1'b0, vmax_s7}) && vnew_s7 >= -$signed({1'b0, vmax_s7})))
		else $error("velocity outside limit at write-back");

	a_clamp_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s7 && clamped_s7) |->
			(vnew_s7 == $signed({1'b0, vmax_s7}) || vnew_s7 == -$signed({1'b0, vmax_s7})))
		else $error("clamped velocity not at limit");

	a_init_not_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_INIT) |-> !res_q.was_clamped)
		else $error("init result flagged as clamped");

endmodule
